>>> hdl/delayed_relay_scheduler_macros.svh
// ----------------------------------------------------------------------------
// delayed relay scheduler assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef DELAYED_RELAY_SCHEDULER_MACROS_SVH
`define DELAYED_RELAY_SCHEDULER_MACROS_SVH

// same-cycle implication, off while reset is high
`define DRS_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("delayed relay scheduler check failed");

// next-cycle implication, off while reset is high
`define DRS_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("delayed relay scheduler check failed");

// next-cycle implication that also holds across reset
`define DRS_ASSERT_ALWAYS(name, clk, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("delayed relay scheduler check failed");

`endif

>>> hdl/drs_pkg.sv
// ----------------------------------------------------------------------------
// drs_pkg
// shared types and constants of the delayed relay scheduler
// ----------------------------------------------------------------------------
package drs_pkg;

  localparam int MAX_RELAYS      = 16;
  localparam int DEF_RELAY_COUNT = 4;
  localparam int DEF_TIME_BITS   = 32;
  localparam int MS_PER_SEC      = 1000;

  localparam int FIELD_W     = 4;
  localparam int IDX_W       = 8;
  localparam int DELAY_W     = 8;
  localparam int NOW_W       = 32;
  localparam int DELAY_MS_W  = 17;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 16;
  localparam int ACTION_W    = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_SCHEDULE   = 2'd0,
    ACT_UNSCHEDULE = 2'd1,
    ACT_TICK       = 2'd2
  } action_t;

  typedef struct packed {
    action_t                    action;
    logic [IDX_W-1:0]           relay_index;
    logic                       switch_on;
    logic signed [DELAY_W-1:0]  delay_sec;
    logic [NOW_W-1:0]           now_ms;
  } cmd_t;

  typedef struct packed {
    logic [FIELD_W-1:0] pin_levels;
    logic [FIELD_W-1:0] fired_mask;
    logic               accepted;
  } result_t;

endpackage

>>> hdl/drs_in_stage.sv
// ----------------------------------------------------------------------------
// drs_in_stage
// input register holding one command beat ahead of the timer bank
// ----------------------------------------------------------------------------
module drs_in_stage import drs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  cmd_t in_cmd,
  input  logic take,
  output logic cmd_valid,
  output cmd_t cmd
);

  // a held beat moves on whenever the result register can take it
  assign in_ready = !cmd_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (in_ready) begin
      cmd_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd <= in_cmd;
    end
  end

endmodule

>>> hdl/drs_timer_core.sv
// ----------------------------------------------------------------------------
// drs_timer_core
// relay timer state and the combinational schedule, cancel and tick logic
// ----------------------------------------------------------------------------
module drs_timer_core import drs_pkg::*; #(
  parameter int RELAY_COUNT = DEF_RELAY_COUNT,
  parameter int TIME_BITS   = DEF_TIME_BITS
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  cmd_t    cmd,
  output result_t result
);

  localparam int SEL_W = (RELAY_COUNT > 1) ? $clog2(RELAY_COUNT) : 1;

  logic                 pending       [RELAY_COUNT];
  logic                 pending_next  [RELAY_COUNT];
  logic [TIME_BITS-1:0] deadline      [RELAY_COUNT];
  logic [TIME_BITS-1:0] deadline_next [RELAY_COUNT];
  logic                 level         [RELAY_COUNT];
  logic                 level_next    [RELAY_COUNT];
  logic [RELAY_COUNT-1:0] pin_state;
  logic [RELAY_COUNT-1:0] pin_state_next;
  logic [RELAY_COUNT-1:0] fired;

  logic [TIME_BITS-1:0]  now_t;
  logic [DELAY_MS_W-1:0] delay_ms;
  logic [TIME_BITS-1:0]  deadline_new;
  logic                  idx_ok;
  logic [SEL_W-1:0]      sel;
  logic                  accepted;
  logic [MAX_RELAYS-1:0] pin_pad;
  logic [MAX_RELAYS-1:0] fired_pad;

  assign now_t        = TIME_BITS'(cmd.now_ms);
  // delay is known non-negative when used, so only the low seven bits count
  assign delay_ms     = DELAY_MS_W'(cmd.delay_sec[DELAY_W-2:0]) * DELAY_MS_W'(MS_PER_SEC);
  assign deadline_new = now_t + TIME_BITS'(delay_ms);
  assign idx_ok       = cmd.relay_index < IDX_W'(RELAY_COUNT);
  assign sel          = cmd.relay_index[SEL_W-1:0];

  always_comb begin
    pending_next   = pending;
    deadline_next  = deadline;
    level_next     = level;
    pin_state_next = pin_state;
    fired          = '0;
    accepted       = 1'b0;
    unique case (cmd.action)
      ACT_SCHEDULE: begin
        if (idx_ok && !cmd.delay_sec[DELAY_W-1]) begin
          pending_next[sel]  = 1'b1;
          deadline_next[sel] = deadline_new;
          level_next[sel]    = cmd.switch_on;
          accepted           = 1'b1;
        end
      end
      ACT_UNSCHEDULE: begin
        if (idx_ok) begin
          pending_next[sel] = 1'b0;
          accepted          = 1'b1;
        end
      end
      ACT_TICK: begin
        for (int i = 0; i < RELAY_COUNT; i++) begin
          if (pending[i] && (deadline[i] <= now_t)) begin
            pending_next[i]   = 1'b0;
            fired[i]          = 1'b1;
            // active-low pin: switching on pulls it to zero
            pin_state_next[i] = !level[i];
          end
        end
        accepted = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    pin_pad   = '0;
    fired_pad = '0;
    pin_pad[RELAY_COUNT-1:0]   = pin_state_next;
    fired_pad[RELAY_COUNT-1:0] = fired;
  end

  assign result.pin_levels = pin_pad[FIELD_W-1:0];
  assign result.fired_mask = fired_pad[FIELD_W-1:0];
  assign result.accepted   = accepted;

  always_ff @(posedge clk) begin
    if (rst) begin
      pin_state <= '1;
      for (int i = 0; i < RELAY_COUNT; i++) begin
        pending[i] <= 1'b0;
      end
    end else if (fire) begin
      pin_state <= pin_state_next;
      pending   <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      deadline <= deadline_next;
      level    <= level_next;
    end
  end

endmodule

>>> hdl/drs_out_stage.sv
// ----------------------------------------------------------------------------
// drs_out_stage
// result register that holds one result beat until the sink takes it
// ----------------------------------------------------------------------------
module drs_out_stage import drs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   res_valid,
  input  result_t                res,
  output logic                   take,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  assign take = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= res_valid;
    end
  end

  // pin_levels in the low bits, then fired_mask, then accepted
  always_ff @(posedge clk) begin
    if (res_valid && take) begin
      m_tdata <= OUT_TDATA_W'({res.accepted, res.fired_mask, res.pin_levels});
    end
  end

endmodule

>>> hdl/delayed_relay_scheduler.sv
// ----------------------------------------------------------------------------
// delayed_relay_scheduler
// four relay timers armed, cancelled and fired by a command stream
// ----------------------------------------------------------------------------
// channel   dir  beat contents
// s_axis    in   tuser: action; tdata: relay_index, switch_on, delay_sec, now_ms
// m_axis    out  tdata: pin_levels, fired_mask, accepted (one beat per command)
//
// each command passes through the timer logic between the input register and
// the result register; a new beat is taken every cycle while s_tready is high
// the timer update (one constant multiply-add and parallel deadline compares)
// sets the cycle; reset clears the pending flags and drives all pins high
// when the sink stalls, one beat waits in each register before s_tready drops
// ----------------------------------------------------------------------------
module delayed_relay_scheduler import drs_pkg::*; #(
  parameter int RELAY_COUNT = DEF_RELAY_COUNT,
  parameter int TIME_BITS   = DEF_TIME_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // relay_index[7:0], switch_on[8], delay_sec[16:9], now_ms[48:17], zero pad
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // action[1:0]
  input  logic [ACTION_W-1:0]    s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // pin_levels[3:0], fired_mask[7:4], accepted[8], zero pad
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  cmd_t    in_cmd;
  cmd_t    cmd;
  logic    cmd_valid;
  logic    take;
  logic    fire;
  result_t result;

  assign in_cmd.action      = action_t'(s_tuser);
  assign in_cmd.relay_index = s_tdata[7:0];
  assign in_cmd.switch_on   = s_tdata[8];
  assign in_cmd.delay_sec   = s_tdata[16:9];
  assign in_cmd.now_ms      = s_tdata[48:17];

  assign fire = cmd_valid && take;

  drs_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_cmd    (in_cmd),
    .take      (take),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  drs_timer_core #(
    .RELAY_COUNT (RELAY_COUNT),
    .TIME_BITS   (TIME_BITS)
  ) u_timer_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .cmd    (cmd),
    .result (result)
  );

  drs_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .res_valid (fire),
    .res       (result),
    .take      (take),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

>>> hdl/drs_checker.sv
// ----------------------------------------------------------------------------
// drs_checker
// port-level checks of the delayed relay scheduler, bound to the top level
// ----------------------------------------------------------------------------
`include "delayed_relay_scheduler_macros.svh"

module drs_checker import drs_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  // a stalled result beat holds
  `DRS_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  // anything that fired came from a tick, which is always accepted
  `DRS_ASSERT_NOW(a_fired_accepted, clk, rst, m_tvalid && (m_tdata[7:4] != 4'd0), m_tdata[8])
  // with the result register empty the input side never stalls
  `DRS_ASSERT_NOW(a_ready_when_empty, clk, rst, !m_tvalid, s_tready)
  // reset leaves no result beat behind
  `DRS_ASSERT_ALWAYS(a_reset_empty, clk, rst, !m_tvalid)

endmodule

bind delayed_relay_scheduler drs_checker u_drs_checker (.*);
